/* src/epct_pkg.sv */
// Shared types, constants and gradient tables for the event pixel color and threshold block.
package epct_pkg;

  localparam int unsigned DECAY_STEPS     = 200;
  localparam int unsigned GRADIENT_POINTS = 10;
  localparam int unsigned TABLE_LEN       = 10;

  localparam int unsigned GLOW_W     = $clog2(DECAY_STEPS + 1);
  localparam int unsigned P_W        = $clog2((GRADIENT_POINTS - 1) * DECAY_STEPS + 1);
  localparam int unsigned FRAC_W     = $clog2(DECAY_STEPS);
  localparam int unsigned IDX_W      = $clog2(TABLE_LEN);
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned DUTY_W     = 10;
  localparam int unsigned THR_W      = 5;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // floor(n / DECAY_STEPS) == (n * RECIP) >> RECIP_SHIFT for every n the datapath sees
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP       = (2**RECIP_SHIFT + DECAY_STEPS - 1) / DECAY_STEPS;
  localparam int unsigned OPND_W      = 17;
  localparam int unsigned ACC_W       = 2 * OPND_W;

  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = 16'd40;
  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST  = 16'd3;
  localparam logic [THR_W-1:0]   CEILING_RST    = 5'b11111;
  localparam logic [THR_W-1:0]   FLOOR_RST      = 5'b00111;
  localparam logic [DUTY_W-1:0]  FLASH_RST      = 10'd500;
  localparam logic [THR_W-1:0]   THR_RST        = 5'b11111;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_LIMIT = 3'd0,
    REG_LOW_LIMIT  = 3'd1,
    REG_CEILING    = 3'd2,
    REG_FLOOR      = 3'd3,
    REG_FLASH      = 3'd4
  } cfg_reg_e;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic [COLOR_W-1:0] GRAD_R [TABLE_LEN] =
    '{8'd0, 8'd4, 8'd50, 8'd100, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
  localparam logic [COLOR_W-1:0] GRAD_G [TABLE_LEN] =
    '{8'd0, 8'd0, 8'd0, 8'd0, 8'd20, 8'd90, 8'd120, 8'd180, 8'd190, 8'd190};
  localparam logic [COLOR_W-1:0] GRAD_B [TABLE_LEN] =
    '{8'd0, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd50, 8'd80, 8'd80};

  typedef enum logic [1:0] {
    MAC_HOLD  = 2'd0,
    MAC_LOAD  = 2'd1,
    MAC_ADD   = 2'd2,
    MAC_SCALE = 2'd3
  } mac_op_e;

  typedef struct packed {
    mac_op_e           op;
    logic [OPND_W-1:0] x;
    logic [OPND_W-1:0] y;
  } mac_req_t;

  typedef struct packed {
    logic [GLOW_W-1:0] glow;
    logic [DUTY_W-1:0] duty;
    logic [THR_W-1:0]  thr;
  } tick_state_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] high_limit;
    logic [LIMIT_W-1:0] low_limit;
    logic [THR_W-1:0]   ceiling;
    logic [THR_W-1:0]   floor_lvl;
    logic [DUTY_W-1:0]  flash;
  } cfg_t;

  function automatic logic [COLOR_W-1:0] grad_val(logic [1:0] ch, logic [IDX_W-1:0] idx);
    logic [COLOR_W-1:0] v;
    v = '0;
    if (idx < IDX_W'(TABLE_LEN)) begin
      unique case (ch)
        CH_RED:   v = GRAD_R[idx];
        CH_GREEN: v = GRAD_G[idx];
        CH_BLUE:  v = GRAD_B[idx];
        default:  v = '0;
      endcase
    end
    return v;
  endfunction

endpackage

/* src/epct_mac.sv */
// Shared multiply-accumulate unit used for the index split and all color blends.
module epct_mac
  import epct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mac_req_t         req_i,
  output logic [ACC_W-1:0] acc_o
);

  logic [ACC_W-1:0]  acc_q, acc_d, prod;
  logic [OPND_W-1:0] mul_a;

  // scale step multiplies the running sum by the reciprocal
  assign mul_a = (req_i.op == MAC_SCALE) ? acc_q[OPND_W-1:0] : req_i.x;
  assign prod  = mul_a * req_i.y;

  always_comb begin
    unique case (req_i.op)
      MAC_HOLD:  acc_d = acc_q;
      MAC_LOAD:  acc_d = prod;
      MAC_ADD:   acc_d = acc_q + prod;
      MAC_SCALE: acc_d = prod;
      default:   acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

/* src/epct_tick.sv */
// Per-tick state: glow decay, flash duty, event counter and threshold adjust.
module epct_tick
  import epct_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        event_seen_i,
  input  logic [7:0]  neighbor_lines_i,
  input  logic        period_end_i,
  input  cfg_t        cfg_i,
  output tick_state_t state_o
);

  localparam int unsigned CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  logic [GLOW_W-1:0]     glow_q, glow_d, glow_ev, glow_cl;
  logic [DUTY_W-1:0]     duty_q, duty_d;
  logic [THR_W-1:0]      thr_q, thr_d, thr_up;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic [CMP_W-1:0]      cnt_x, high_x, low_x;

  always_comb begin
    glow_ev = glow_q;
    duty_d  = duty_q;
    cnt_inc = cnt_q;
    if (event_seen_i) begin
      // any neighbor line low marks a coincidence
      if (neighbor_lines_i != 8'hFF) begin
        glow_ev = GLOW_W'(DECAY_STEPS);
      end else begin
        duty_d = cfg_i.flash;
      end
      if (cnt_q != '1) begin
        cnt_inc = cnt_q + COUNT_BITS'(1);
      end
    end else begin
      duty_d = '0;
    end

    glow_cl = (glow_ev > GLOW_W'(DECAY_STEPS)) ? GLOW_W'(DECAY_STEPS) : glow_ev;
    glow_d  = (glow_cl != '0) ? glow_cl - GLOW_W'(1) : glow_cl;

    cnt_x  = CMP_W'(cnt_inc);
    high_x = CMP_W'(cfg_i.high_limit);
    low_x  = CMP_W'(cfg_i.low_limit);

    // raise first, lower test sees the raised code
    thr_up = (period_end_i && cnt_x > high_x && thr_q < cfg_i.ceiling) ?
             thr_q + THR_W'(1) : thr_q;
    thr_d  = (period_end_i && cnt_x < low_x && thr_up > cfg_i.floor_lvl) ?
             thr_up - THR_W'(1) : thr_up;
    cnt_d  = period_end_i ? '0 : cnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glow_q <= '0;
      duty_q <= '0;
      thr_q  <= THR_RST;
      cnt_q  <= '0;
    end else if (accept_i) begin
      glow_q <= glow_d;
      duty_q <= duty_d;
      thr_q  <= thr_d;
      cnt_q  <= cnt_d;
    end
  end

  assign state_o.glow = glow_q;
  assign state_o.duty = duty_q;
  assign state_o.thr  = thr_q;

endmodule

/* src/event_pixel_color_and_threshold.sv */
// Top level: config registers, blend sequencer and output register.
//
// One request per tick enters on the in channel (event_seen, neighbor_lines,
// period_end) and yields exactly one result on the out channel (flash duty,
// RGB gradient levels, detector threshold code). Configuration writes arrive
// on the cfg channel, which is always ready; index 0..4 selects high limit,
// low limit, threshold ceiling, threshold floor and flash level, and other
// indexes are ignored.
// The tick state updates in the accept cycle; a single multiply-accumulate
// unit then runs the gradient index split (S_DIV, S_FRAC) and a load, add
// and scale step per color channel, and S_OUT loads the output register;
// in_ready_o is low until the sequencer is back in S_IDLE.
// The output register holds a finished result while a new request is
// accepted; if out_ready_i stays low the sequencer waits before writing the
// next result. Reset clears glow, count and duty, sets the threshold to 31
// and loads the register defaults.
module event_pixel_color_and_threshold
  import epct_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  event_seen_i,
  input  logic [7:0]            neighbor_lines_i,
  input  logic                  period_end_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DUTY_W-1:0]     flash_duty_o,
  output logic [COLOR_W-1:0]    red_level_o,
  output logic [COLOR_W-1:0]    green_level_o,
  output logic [COLOR_W-1:0]    blue_level_o,
  output logic [THR_W-1:0]      threshold_level_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_FRAC = 5'b00100,
    S_MAC  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  localparam logic [1:0] STEP_LOAD  = 2'd0;
  localparam logic [1:0] STEP_ADD   = 2'd1;
  localparam logic [1:0] STEP_SCALE = 2'd2;

  state_e             state_q, state_d;
  logic [1:0]         ch_q, ch_d, st_q, st_d;
  logic [IDX_W-1:0]   idx_q, idx_d, idx_nx;
  logic [FRAC_W-1:0]  f_q, f_d;
  logic [COLOR_W-1:0] red_q, red_d, green_q, green_d;
  logic [COLOR_W-1:0] grad_a, grad_b, acc_color;
  logic [P_W-1:0]     p, quo, prem;
  logic [GLOW_W-1:0]  weight_a;
  logic               accept, out_load;
  logic               out_valid_q;
  logic [DUTY_W-1:0]  out_duty_q;
  logic [COLOR_W-1:0] out_red_q, out_green_q, out_blue_q;
  logic [THR_W-1:0]   out_thr_q;
  cfg_t               cfg_q;
  tick_state_t        tick_st;
  mac_req_t           mac_req;
  logic [ACC_W-1:0]   acc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_limit <= HIGH_LIMIT_RST;
      cfg_q.low_limit  <= LOW_LIMIT_RST;
      cfg_q.ceiling    <= CEILING_RST;
      cfg_q.floor_lvl  <= FLOOR_RST;
      cfg_q.flash      <= FLASH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_HIGH_LIMIT: cfg_q.high_limit <= cfg_data_i;
        REG_LOW_LIMIT:  cfg_q.low_limit  <= cfg_data_i;
        REG_CEILING:    cfg_q.ceiling    <= cfg_data_i[THR_W-1:0];
        REG_FLOOR:      cfg_q.floor_lvl  <= cfg_data_i[THR_W-1:0];
        REG_FLASH:      cfg_q.flash      <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  epct_tick #(
    .COUNT_BITS(COUNT_BITS)
  ) u_tick (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .event_seen_i     (event_seen_i),
    .neighbor_lines_i (neighbor_lines_i),
    .period_end_i     (period_end_i),
    .cfg_i            (cfg_q),
    .state_o          (tick_st)
  );

  epct_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .acc_o  (acc)
  );

  // gradient position and its split into segment index and fraction
  assign p         = P_W'(tick_st.glow) * P_W'(GRADIENT_POINTS - 1);
  assign quo       = acc[RECIP_SHIFT +: P_W];
  assign prem      = p - quo * P_W'(DECAY_STEPS);
  assign idx_nx    = idx_q + IDX_W'(1);
  assign grad_a    = grad_val(ch_q, idx_q);
  assign grad_b    = grad_val(ch_q, idx_nx);
  assign weight_a  = GLOW_W'(DECAY_STEPS) - GLOW_W'(f_q);
  assign acc_color = acc[RECIP_SHIFT +: COLOR_W];
  assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    st_d        = st_q;
    idx_d       = idx_q;
    f_d         = f_q;
    red_d       = red_q;
    green_d     = green_q;
    mac_req.op  = MAC_HOLD;
    mac_req.x   = '0;
    mac_req.y   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DIV;
      end
      S_DIV: begin
        mac_req.op = MAC_LOAD;
        mac_req.x  = OPND_W'(p);
        mac_req.y  = OPND_W'(RECIP);
        state_d    = S_FRAC;
      end
      S_FRAC: begin
        // keep the stop point inside the table
        if (quo > P_W'(TABLE_LEN - 2)) begin
          idx_d = IDX_W'(TABLE_LEN - 2);
          f_d   = '0;
        end else begin
          idx_d = quo[IDX_W-1:0];
          f_d   = prem[FRAC_W-1:0];
        end
        ch_d    = CH_RED;
        st_d    = STEP_LOAD;
        state_d = S_MAC;
      end
      S_MAC: begin
        unique case (st_q)
          STEP_LOAD: begin
            mac_req.op = MAC_LOAD;
            mac_req.x  = OPND_W'(grad_a);
            mac_req.y  = OPND_W'(weight_a);
            // previous channel's quotient is still in the accumulator
            if (ch_q == CH_GREEN) red_d   = acc_color;
            if (ch_q == CH_BLUE)  green_d = acc_color;
            st_d = STEP_ADD;
          end
          STEP_ADD: begin
            mac_req.op = MAC_ADD;
            mac_req.x  = OPND_W'(grad_b);
            mac_req.y  = OPND_W'(f_q);
            st_d       = STEP_SCALE;
          end
          STEP_SCALE: begin
            mac_req.op = MAC_SCALE;
            mac_req.y  = OPND_W'(RECIP);
            st_d       = STEP_LOAD;
            if (ch_q == CH_BLUE) begin
              state_d = S_OUT;
            end else begin
              ch_d = ch_q + 2'd1;
            end
          end
          default: st_d = STEP_LOAD;
        endcase
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= CH_RED;
      st_q        <= STEP_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      st_q    <= st_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    f_q     <= f_d;
    red_q   <= red_d;
    green_q <= green_d;
    if (out_load) begin
      out_duty_q  <= tick_st.duty;
      out_red_q   <= red_q;
      out_green_q <= green_q;
      out_blue_q  <= acc_color;
      out_thr_q   <= tick_st.thr;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign flash_duty_o      = out_duty_q;
  assign red_level_o       = out_red_q;
  assign green_level_o     = out_green_q;
  assign blue_level_o      = out_blue_q;
  assign threshold_level_o = out_thr_q;

`ifndef SYNTHESIS
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after a request");

  a_thr_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !period_end_i |=> tick_st.thr == $past(tick_st.thr))
    else $error("threshold moved without period end");

  a_mac_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MAC |-> (ch_q <= CH_BLUE && st_q <= STEP_SCALE))
    else $error("blend sequencer out of range");

  a_out_return : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && (!out_valid_q || out_ready_i) |=> state_q == S_IDLE && out_valid_q)
    else $error("result load did not complete");
`endif

endmodule
